// ===== rtl/block2_sparse_matvec_core_assert.svh =====
// Assertion shorthands for the sparse block matvec checks.
// Each check samples on the rising edge of clk and is off while rst is high.
`ifndef BLOCK2_SPARSE_MATVEC_CORE_ASSERT_SVH
`define BLOCK2_SPARSE_MATVEC_CORE_ASSERT_SVH

// Same-cycle implication.
`define BSM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sparse matvec check failed");

// Next-cycle implication.
`define BSM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sparse matvec check failed");

`endif

// ===== rtl/bsm_pkg.sv =====
package bsm_pkg;

  localparam int X_BLOCKS_DEF  = 1024;
  localparam int MAX_ROWS_DEF  = 4096;
  localparam int FRAC_BITS_DEF = 24;

  localparam int DATA_W     = 32;
  localparam int ACC_W      = 64;
  localparam int OPCODE_W   = 2;
  localparam int COL_W      = 10;
  localparam int ROW_NUM_W  = 12;
  localparam int ROW_CNT_W  = 13;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 13;

  localparam logic [ROW_CNT_W-1:0] ROW_COUNT_RESET = 13'd4096;

  typedef logic signed [DATA_W-1:0] data_t;
  typedef logic signed [ACC_W-1:0]  acc_t;

  typedef enum logic [OPCODE_W-1:0] {
    OP_LOAD_X    = 2'd0,
    OP_BLOCK     = 2'd1,
    OP_EMPTY_ROW = 2'd2
  } opcode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ADD_MODE  = 1'b0,
    CFG_ROW_COUNT = 1'b1
  } cfg_reg_t;

endpackage

// ===== rtl/bsm_in_if.sv =====
interface bsm_in_if;
  logic                             valid;
  logic                             ready;
  logic [bsm_pkg::OPCODE_W-1:0]     opcode;
  logic [bsm_pkg::COL_W-1:0]        block_col;
  bsm_pkg::data_t                   a00;
  bsm_pkg::data_t                   a01;
  bsm_pkg::data_t                   a10;
  bsm_pkg::data_t                   a11;
  bsm_pkg::data_t                   xval0;
  bsm_pkg::data_t                   xval1;
  bsm_pkg::data_t                   bias0;
  bsm_pkg::data_t                   bias1;
  logic                             first_in_row;
  logic                             last_in_row;

  modport source (
    output valid, opcode, block_col, a00, a01, a10, a11, xval0, xval1, bias0, bias1,
           first_in_row, last_in_row,
    input  ready
  );

  modport sink (
    input  valid, opcode, block_col, a00, a01, a10, a11, xval0, xval1, bias0, bias1,
           first_in_row, last_in_row,
    output ready
  );
endinterface

// ===== rtl/bsm_out_if.sv =====
interface bsm_out_if;
  logic                          valid;
  logic                          ready;
  bsm_pkg::data_t                out0;
  bsm_pkg::data_t                out1;
  logic [bsm_pkg::ROW_NUM_W-1:0] row_number;
  logic                          saturated;

  modport source (
    output valid, out0, out1, row_number, saturated,
    input  ready
  );

  modport sink (
    input  valid, out0, out1, row_number, saturated,
    output ready
  );
endinterface

// ===== rtl/bsm_ram.sv =====
module bsm_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/block2_sparse_matvec_core.sv =====
// Sparse matrix times vector over 2x2 blocks streamed in block-row (CSR) order.
// Input channel "items" carries one beat per command: load an x pair into the
// x store, stream one nonzero block with its block column, or mark an empty row.
// Output channel "results" carries one beat per finished block row: two Q8.24
// values, the row index and a clip flag. Configuration writes (add_mode,
// row_count) go through cfg_we/cfg_index/cfg_data; the user makes them only
// while the block is idle, which the block does not enforce. Throughput: one
// input beat per cycle for any opcode mix, sustained while results.ready is
// high. A row result passes the x store read, multiply, accumulate and then
// the output register. The accumulator loop closes in the accumulate stage, so
// consecutive blocks of one row follow each other with no gap.
// A load is written to the x store at its beat; a later block reads the new
// value, so no forwarding is needed.
// Reset clears the accumulators, the row counter, the clip flag, add_mode and
// row_count (4096) at once; there is no clearing pass and the x store stays
// unwritten. When the receiver stalls, the output register holds its beat and
// the pipeline behind it keeps filling its empty stages before items.ready drops.
module block2_sparse_matvec_core #(
  parameter int X_BLOCKS  = bsm_pkg::X_BLOCKS_DEF,
  parameter int MAX_ROWS  = bsm_pkg::MAX_ROWS_DEF,
  parameter int FRAC_BITS = bsm_pkg::FRAC_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  bsm_in_if.sink                           items,
  bsm_out_if.source                        results,
  input  logic                             cfg_we,
  input  logic [bsm_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bsm_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int AW    = (X_BLOCKS > 1) ? $clog2(X_BLOCKS) : 1;
  localparam int RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int LIM_W = $clog2(MAX_ROWS + 1);
  localparam int DW    = bsm_pkg::DATA_W;
  localparam int AccW  = bsm_pkg::ACC_W;

  localparam bsm_pkg::acc_t ACC_MAX = {1'b0, {(AccW-1){1'b1}}};
  localparam bsm_pkg::acc_t ACC_MIN = {1'b1, {(AccW-1){1'b0}}};
  localparam bsm_pkg::data_t OUT_MAX = {1'b0, {(DW-1){1'b1}}};
  localparam bsm_pkg::data_t OUT_MIN = {1'b1, {(DW-1){1'b0}}};

  // Two saturating adds in a row: sat(sat(a + p) + q). Both sums are formed in
  // parallel; the clip of the first add picks the limit-plus-q path.
  // Returns {clip, result}.
  function automatic logic [AccW:0] sat_add2(bsm_pkg::acc_t a, bsm_pkg::acc_t p,
                                             bsm_pkg::acc_t q);
    logic signed [AccW+1:0] s1;
    logic signed [AccW+1:0] s12;
    logic                   fit1;
    logic                   fit12;
    bsm_pkg::acc_t          res;
    logic                   clip;
    s1    = (AccW+2)'(a) + (AccW+2)'(p);
    s12   = s1 + (AccW+2)'(q);
    fit1  = (s1[AccW+1:AccW-1] == 3'b000) || (s1[AccW+1:AccW-1] == 3'b111);
    fit12 = (s12[AccW+1:AccW-1] == 3'b000) || (s12[AccW+1:AccW-1] == 3'b111);
    if (!fit1 && !s1[AccW+1]) begin
      clip = 1'b1;
      res  = (q > 0) ? ACC_MAX : ACC_MAX + q;
    end else if (!fit1) begin
      clip = 1'b1;
      res  = (q < 0) ? ACC_MIN : ACC_MIN + q;
    end else if (!fit12) begin
      clip = 1'b1;
      res  = s12[AccW+1] ? ACC_MIN : ACC_MAX;
    end else begin
      clip = 1'b0;
      res  = s12[AccW-1:0];
    end
    return {clip, res};
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic                            add_mode;
  logic [bsm_pkg::ROW_CNT_W-1:0]   row_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      add_mode  <= 1'b0;
      row_count <= bsm_pkg::ROW_COUNT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bsm_pkg::CFG_ADD_MODE:  add_mode  <= cfg_data[0];
        bsm_pkg::CFG_ROW_COUNT: row_count <= cfg_data[bsm_pkg::ROW_CNT_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or its beat moves
  // on; a block that does not close a row leaves the accumulate stage without
  // needing the output register.
  // ---------------------------------------------------------------------------
  logic v1, v2, v3;
  logic emit2;
  logic load1, load2, load3, go2;
  logic in_acc;

  assign load3 = !v3 || results.ready;
  assign go2   = v2 && (!emit2 || load3);
  assign load2 = !v2 || go2;
  assign load1 = !v1 || load2;

  assign items.ready = load1;
  assign in_acc      = items.valid && items.ready;

  // ---------------------------------------------------------------------------
  // Stage 0: decode the beat, write or read the x store
  // ---------------------------------------------------------------------------
  logic is_load, is_blk, is_empty, col_ok;
  logic [2*DW-1:0] ram_rdata;
  bsm_pkg::acc_t   start0, start1;

  assign is_load  = items.opcode == bsm_pkg::OP_LOAD_X;
  assign is_blk   = items.opcode == bsm_pkg::OP_BLOCK;
  assign is_empty = items.opcode == bsm_pkg::OP_EMPTY_ROW;
  assign col_ok   = 32'(items.block_col) < 32'(X_BLOCKS);

  // Row start value: zero, or the bias moved up to the accumulator's point.
  assign start0 = add_mode ? (bsm_pkg::acc_t'(items.bias0) <<< FRAC_BITS) : '0;
  assign start1 = add_mode ? (bsm_pkg::acc_t'(items.bias1) <<< FRAC_BITS) : '0;

  bsm_ram #(
    .WIDTH (2 * DW),
    .DEPTH (X_BLOCKS)
  ) u_x_store (
    .clk   (clk),
    .we    (in_acc && is_load && col_ok),
    .waddr (AW'(items.block_col)),
    .wdata ({items.xval1, items.xval0}),
    .re    (in_acc),
    .raddr (AW'(items.block_col)),
    .rdata (ram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Stage 1: x pair arrives from the store, form the four exact products
  // ---------------------------------------------------------------------------
  bsm_pkg::data_t a00_1, a01_1, a10_1, a11_1;
  bsm_pkg::acc_t  start0_1, start1_1;
  logic           zero_x1, first1, emit1;
  bsm_pkg::data_t x0, x1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (load1) begin
      // Loads and unused codes leave no beat behind in the pipeline.
      v1 <= in_acc && (is_blk || is_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (load1) begin
      a00_1    <= items.a00;
      a01_1    <= items.a01;
      a10_1    <= items.a10;
      a11_1    <= items.a11;
      start0_1 <= start0;
      start1_1 <= start1;
      // An empty row behaves as a one-block row whose products are zero.
      zero_x1  <= is_empty || !col_ok;
      first1   <= is_empty || items.first_in_row;
      emit1    <= is_empty || items.last_in_row;
    end
  end

  assign x0 = zero_x1 ? '0 : ram_rdata[DW-1:0];
  assign x1 = zero_x1 ? '0 : ram_rdata[2*DW-1:DW];

  // ---------------------------------------------------------------------------
  // Stage 2: saturating accumulate into the row registers
  // ---------------------------------------------------------------------------
  bsm_pkg::acc_t p00_2, p01_2, p10_2, p11_2;
  bsm_pkg::acc_t start0_2, start1_2;
  logic          first2;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (load2) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (load2) begin
      p00_2    <= bsm_pkg::acc_t'(a00_1) * bsm_pkg::acc_t'(x0);
      p01_2    <= bsm_pkg::acc_t'(a01_1) * bsm_pkg::acc_t'(x1);
      p10_2    <= bsm_pkg::acc_t'(a10_1) * bsm_pkg::acc_t'(x0);
      p11_2    <= bsm_pkg::acc_t'(a11_1) * bsm_pkg::acc_t'(x1);
      start0_2 <= start0_1;
      start1_2 <= start1_1;
      first2   <= first1;
      emit2    <= emit1;
    end
  end

  bsm_pkg::acc_t   accum0, accum1;
  logic            sat_flag;
  logic [RW-1:0]   row_counter;
  bsm_pkg::acc_t   base0, base1, accum0_next, accum1_next;
  logic [AccW:0]   sum0, sum1;
  logic            sat_flag_next;
  logic [LIM_W-1:0] row_limit, row_inc;
  logic [RW-1:0]   row_counter_next;

  assign base0 = first2 ? start0_2 : accum0;
  assign base1 = first2 ? start1_2 : accum1;
  assign sum0  = sat_add2(base0, p00_2, p01_2);
  assign sum1  = sat_add2(base1, p10_2, p11_2);

  assign accum0_next   = sum0[AccW-1:0];
  assign accum1_next   = sum1[AccW-1:0];
  assign sat_flag_next = (!first2 && sat_flag) || sum0[AccW] || sum1[AccW];

  // Out-of-range row_count falls back to the full row space.
  assign row_limit = (row_count == '0 || 32'(row_count) > 32'(MAX_ROWS)) ?
                     LIM_W'(MAX_ROWS) : LIM_W'(row_count);
  assign row_inc   = LIM_W'(row_counter) + LIM_W'(1);
  assign row_counter_next = (row_inc >= row_limit) ? '0 : RW'(row_inc);

  always_ff @(posedge clk) begin
    if (rst) begin
      accum0      <= '0;
      accum1      <= '0;
      sat_flag    <= 1'b0;
      row_counter <= '0;
    end else if (go2) begin
      accum0   <= accum0_next;
      accum1   <= accum1_next;
      sat_flag <= sat_flag_next;
      if (emit2) begin
        row_counter <= row_counter_next;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: output register; scale down and clip on the way out
  // ---------------------------------------------------------------------------
  bsm_pkg::acc_t                 acc0_3, acc1_3;
  logic                          sat3;
  logic [bsm_pkg::ROW_NUM_W-1:0] row3;
  bsm_pkg::acc_t                 q0, q1;
  logic                          fit0, fit1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (load3) begin
      v3 <= go2 && emit2;
    end
  end

  always_ff @(posedge clk) begin
    if (load3) begin
      acc0_3 <= accum0_next;
      acc1_3 <= accum1_next;
      sat3   <= sat_flag_next;
      row3   <= bsm_pkg::ROW_NUM_W'(row_counter);
    end
  end

  // Arithmetic shift rounds toward minus infinity.
  assign q0   = acc0_3 >>> FRAC_BITS;
  assign q1   = acc1_3 >>> FRAC_BITS;
  assign fit0 = (&q0[AccW-1:DW-1]) || !(|q0[AccW-1:DW-1]);
  assign fit1 = (&q1[AccW-1:DW-1]) || !(|q1[AccW-1:DW-1]);

  assign results.valid      = v3;
  assign results.out0       = fit0 ? q0[DW-1:0] : (q0[AccW-1] ? OUT_MIN : OUT_MAX);
  assign results.out1       = fit1 ? q1[DW-1:0] : (q1[AccW-1] ? OUT_MIN : OUT_MAX);
  assign results.row_number = row3;
  assign results.saturated  = sat3 || !fit0 || !fit1;

endmodule

// ===== rtl/bsm_checker.sv =====
`include "block2_sparse_matvec_core_assert.svh"

module bsm_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          in_ready,
  input logic                          out_valid,
  input logic                          out_ready,
  input bsm_pkg::data_t                out0,
  input bsm_pkg::data_t                out1,
  input logic [bsm_pkg::ROW_NUM_W-1:0] row_number,
  input logic                          saturated
);

  logic                          seen;
  logic [bsm_pkg::ROW_NUM_W-1:0] prev_row;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_valid && out_ready) begin
      prev_row <= row_number;
    end
  end

  // A stalled result beat holds its payload.
  `BSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready,
    out_valid && $stable(out0) && $stable(out1) && $stable(row_number) && $stable(saturated))

  // With the output register empty nothing can block the input.
  `BSM_ASSERT_NOW(a_ready_when_drained, !out_valid, in_ready)

  // Row numbers advance by one or wrap to zero.
  `BSM_ASSERT_NOW(a_row_order, out_valid && seen,
    (row_number == prev_row + 1'b1) || (row_number == '0))

endmodule

bind block2_sparse_matvec_core bsm_checker u_bsm_checker (
  .clk        (clk),
  .rst        (rst),
  .in_ready   (items.ready),
  .out_valid  (results.valid),
  .out_ready  (results.ready),
  .out0       (results.out0),
  .out1       (results.out1),
  .row_number (results.row_number),
  .saturated  (results.saturated)
);
